FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hdl/isl_pkg.sv
// Types and constants for the indexed shift list.
// Used by isl_cell, isl_ctrl and indexed_shift_list_top.
`default_nettype none
package isl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_INSERT = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_DELETE,
        CELL_INSERT
    } cell_mode_t;

    typedef struct packed {
        req_type_t                 req_type;
        logic [IDX_W-1:0]          loc;
        logic signed [DATA_W-1:0]  data;
    } req_t;

    typedef struct packed {
        logic                      status;
        logic [CNT_W-1:0]          count;
        logic [CNT_W-1:0]          capacity;
        logic signed [DATA_W-1:0]  value_at_loc;
    } rsp_t;

    typedef struct packed {
        cell_mode_t                mode;
        logic [IDX_W-1:0]          loc;
        logic [CNT_W-1:0]          count;
        logic signed [DATA_W-1:0]  data;
    } cell_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic [CNT_W-1:0]          capacity;
    } list_state_t;

endpackage
`default_nettype wire

FILE: hdl/indexed_shift_list_top.sv
// Indexed shift list: a row of entry cells shifted in parallel for insert and delete.
// The response is registered at the request transfer and is valid from the cycle after it.
// Throughput: one request per cycle unless a held response stalls; the whole row updates together.
// A held response stalls requests until it transfers; both may transfer in one cycle.
// Reset clears count, capacity and the response valid; entry contents are not reset.
// Depends on isl_pkg, isl_ctrl, isl_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module indexed_shift_list_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire isl_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output isl_pkg::rsp_t      rsp
);

    logic                 accept;
    logic                 status;
    isl_pkg::cell_ctl_t   ctl;
    isl_pkg::list_state_t st;
    isl_pkg::list_state_t st_next;

    logic signed [isl_pkg::DATA_W-1:0] entry_q    [isl_pkg::CAPACITY];
    logic signed [isl_pkg::DATA_W-1:0] entry_d    [isl_pkg::CAPACITY];
    logic signed [isl_pkg::DATA_W-1:0] left_in    [isl_pkg::CAPACITY];
    logic signed [isl_pkg::DATA_W-1:0] right_in   [isl_pkg::CAPACITY];

    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    isl_pkg::rsp_t        rsp_reg;
    isl_pkg::rsp_t        rsp_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    isl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (req),
        .ctl     (ctl),
        .status  (status),
        .st      (st),
        .st_next (st_next)
    );

    for (genvar g = 0; g < isl_pkg::CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_in[g] = '0;
        end
        else
        begin : g_mid_l
            assign left_in[g] = entry_q[g-1];
        end
        if (g == isl_pkg::CAPACITY - 1)
        begin : g_last
            assign right_in[g] = '0;
        end
        else
        begin : g_mid_r
            assign right_in[g] = entry_q[g+1];
        end

        isl_cell u_cell (
            .clk      (clk),
            .idx      (isl_pkg::IDX_W'(g)),
            .ctl      (ctl),
            .left_in  (left_in[g]),
            .right_in (right_in[g]),
            .q        (entry_q[g]),
            .d        (entry_d[g])
        );
    end

    always_comb
    begin
        rsp_next.status       = status;
        rsp_next.count        = st_next.count;
        rsp_next.capacity     = st_next.capacity;
        rsp_next.value_at_loc = '0;
        if (isl_pkg::CNT_W'(req.loc) < st_next.count)
        begin
            rsp_next.value_at_loc = entry_d[req.loc];
        end
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_PROP(a_cnt_le_cap, clk, rst_n, st.count <= st.capacity)
    `ASSERT_PROP(a_cap_pow2, clk, rst_n, $onehot0(st.capacity))
    `ASSERT_PROP(a_fail_keeps_count, clk, rst_n, (accept && status) |=> (st.count == $past(st.count)))
    `ASSERT_NEVER(a_cap_over, clk, rst_n, st.capacity > isl_pkg::CNT_W'(isl_pkg::CAPACITY))

endmodule
`default_nettype wire

FILE: hdl/isl_cell.sv
// One list entry: holds a word and takes a new one from itself, a neighbor or the request.
// Depends on isl_pkg.
`default_nettype none
module isl_cell (
    input  wire logic                              clk,
    input  wire logic [isl_pkg::IDX_W-1:0]         idx,
    input  wire isl_pkg::cell_ctl_t                ctl,
    input  wire logic signed [isl_pkg::DATA_W-1:0] left_in,
    input  wire logic signed [isl_pkg::DATA_W-1:0] right_in,
    output logic signed [isl_pkg::DATA_W-1:0]      q,
    output logic signed [isl_pkg::DATA_W-1:0]      d
);

    logic signed [isl_pkg::DATA_W-1:0] entry_reg;
    logic signed [isl_pkg::DATA_W-1:0] entry_next;
    logic [isl_pkg::CNT_W-1:0]         idx_ext;
    logic [isl_pkg::CNT_W-1:0]         idx_inc;
    logic [isl_pkg::CNT_W-1:0]         loc_ext;

    assign idx_ext = isl_pkg::CNT_W'(idx);
    assign idx_inc = idx_ext + isl_pkg::CNT_W'(1);
    assign loc_ext = isl_pkg::CNT_W'(ctl.loc);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.mode)
            isl_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            isl_pkg::CELL_WRITE:
            begin
                if (idx == ctl.loc)
                begin
                    entry_next = ctl.data;
                end
            end
            isl_pkg::CELL_DELETE:
            begin
                if ((idx_ext >= loc_ext) && (idx_inc < ctl.count))
                begin
                    entry_next = right_in;
                end
            end
            isl_pkg::CELL_INSERT:
            begin
                if (idx == ctl.loc)
                begin
                    entry_next = ctl.data;
                end
                else if ((idx_ext > loc_ext) && (idx_ext <= ctl.count))
                begin
                    entry_next = left_in;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;
    assign d = entry_next;

endmodule
`default_nettype wire

FILE: hdl/isl_ctrl.sv
// Count and capacity registers, grow/shrink policy and cell command decode.
// Depends on isl_pkg.
`default_nettype none
module isl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire isl_pkg::req_t      req,
    output isl_pkg::cell_ctl_t      ctl,
    output logic                    status,
    output isl_pkg::list_state_t    st,
    output isl_pkg::list_state_t    st_next
);

    logic [isl_pkg::CNT_W-1:0] count_reg;
    logic [isl_pkg::CNT_W-1:0] count_next;
    logic [isl_pkg::CNT_W-1:0] cap_reg;
    logic [isl_pkg::CNT_W-1:0] cap_next;

    logic [isl_pkg::CNT_W-1:0] loc_ext;
    logic [isl_pkg::CNT_W:0]   cap_dbl;
    logic [isl_pkg::CNT_W-1:0] cap_room;
    logic                      room_ok;
    logic                      add_ok;
    logic [isl_pkg::CNT_W-1:0] cnt_del;
    logic [isl_pkg::CNT_W-1:0] cap_half;

    assign loc_ext  = isl_pkg::CNT_W'(req.loc);
    assign cap_dbl  = {cap_reg, 1'b0};
    assign cap_half = cap_reg >> 1;

    // grow policy
    always_comb
    begin
        room_ok  = 1'b1;
        cap_room = cap_reg;
        if (cap_reg == '0)
        begin
            cap_room = isl_pkg::CNT_W'(1);
        end
        else if (count_reg < cap_reg)
        begin
            cap_room = cap_reg;
        end
        else if (cap_reg >= isl_pkg::CNT_W'(isl_pkg::CAPACITY))
        begin
            room_ok = 1'b0;
        end
        else if (cap_dbl > (isl_pkg::CNT_W + 1)'(isl_pkg::CAPACITY))
        begin
            cap_room = isl_pkg::CNT_W'(isl_pkg::CAPACITY);
        end
        else
        begin
            cap_room = cap_dbl[isl_pkg::CNT_W-1:0];
        end
    end

    assign add_ok  = room_ok && (count_reg < isl_pkg::CNT_W'(isl_pkg::CAPACITY));
    assign cnt_del = (loc_ext < count_reg) ? count_reg - isl_pkg::CNT_W'(1) : count_reg;

    always_comb
    begin
        count_next = count_reg;
        cap_next   = cap_reg;
        status     = 1'b0;
        ctl.mode   = isl_pkg::CELL_HOLD;
        ctl.loc    = req.loc;
        ctl.count  = count_reg;
        ctl.data   = req.data;
        case (req.req_type)
            isl_pkg::REQ_UPDATE:
            begin
                if (loc_ext < count_reg)
                begin
                    ctl.mode = isl_pkg::CELL_WRITE;
                end
                else
                begin
                    status = 1'b1;
                end
            end
            isl_pkg::REQ_DELETE:
            begin
                ctl.mode   = isl_pkg::CELL_DELETE;
                count_next = cnt_del;
                if (cnt_del < cap_half)
                begin
                    cap_next = cap_half;
                end
                if (cnt_del == '0)
                begin
                    cap_next = '0;
                end
            end
            isl_pkg::REQ_APPEND:
            begin
                cap_next = cap_room;
                ctl.loc  = count_reg[isl_pkg::IDX_W-1:0];
                if (add_ok)
                begin
                    ctl.mode   = isl_pkg::CELL_WRITE;
                    count_next = count_reg + isl_pkg::CNT_W'(1);
                end
                else
                begin
                    status = 1'b1;
                end
            end
            isl_pkg::REQ_INSERT:
            begin
                if (loc_ext > count_reg)
                begin
                    status = 1'b1;
                end
                else
                begin
                    cap_next = cap_room;
                    if (add_ok)
                    begin
                        ctl.mode   = isl_pkg::CELL_INSERT;
                        count_next = count_reg + isl_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        status = 1'b1;
                    end
                end
            end
            default:
            begin
                status = 1'b1;
            end
        endcase
        if (!accept)
        begin
            ctl.mode   = isl_pkg::CELL_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    assign st.count         = count_reg;
    assign st.capacity      = cap_reg;
    assign st_next.count    = count_next;
    assign st_next.capacity = cap_next;

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for indexed_shift_list_top: directed and random list requests.
// Predicts every response from a local list model and checks transfers in order.
// Depends on isl_pkg and the indexed_shift_list_top RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import isl_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    indexed_shift_list_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    logic signed [DATA_W-1:0] mirror [CAPACITY];
    int unsigned n_elems = 0;
    int unsigned cap_now = 0;

    int err_count = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int drv_calm = 0;
    int mon_calm = 0;
    int gen_count = 0;
    rsp_t want;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // grow policy: 0 -> 1, then double when full, saturate at CAPACITY
    function automatic bit room_ok();
        if (cap_now == 0)
        begin
            cap_now = 1;
            return 1'b1;
        end
        if (n_elems < cap_now)
            return 1'b1;
        if (cap_now >= CAPACITY)
            return 1'b0;
        cap_now = cap_now * 2;
        if (cap_now > CAPACITY)
            cap_now = CAPACITY;
        return 1'b1;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int unsigned at;
        int unsigned i;
        bit ok;
        res = '0;
        ok = 1'b1;
        at = r.loc;
        case (r.req_type)
            REQ_UPDATE:
            begin
                if (at < n_elems)
                    mirror[at] = r.data;
                else
                    ok = 1'b0;
            end
            REQ_DELETE:
            begin
                // out-of-range delete still runs the shrink checks and succeeds
                if (at < n_elems)
                begin
                    for (i = at; i + 1 < n_elems; i++)
                        mirror[i] = mirror[i + 1];
                    n_elems--;
                end
                if (n_elems < cap_now / 2)
                    cap_now = cap_now / 2;
                if (n_elems == 0)
                    cap_now = 0;
            end
            REQ_APPEND:
            begin
                if (room_ok() && n_elems < CAPACITY)
                begin
                    mirror[n_elems] = r.data;
                    n_elems++;
                end
                else
                    ok = 1'b0;
            end
            default:
            begin
                if (at > n_elems)
                    ok = 1'b0;
                else if (room_ok() && n_elems < CAPACITY)
                begin
                    for (i = n_elems; i > at; i--)
                        mirror[i] = mirror[i - 1];
                    mirror[at] = r.data;
                    n_elems++;
                end
                else
                    ok = 1'b0;
            end
        endcase
        res.status = !ok;
        res.count = n_elems[CNT_W-1:0];
        res.capacity = cap_now[CNT_W-1:0];
        res.value_at_loc = (at < n_elems) ? mirror[at] : '0;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // tracks only the element count so generated indexes land mostly in range
    task automatic add_item(input req_type_t op, input int at, input logic [DATA_W-1:0] d);
        req_t r;
        r.req_type = op;
        r.loc = at[IDX_W-1:0];
        r.data = d;
        pending_reqs.push_back(r);
        case (op)
            REQ_DELETE:
            begin
                if (r.loc < gen_count)
                    gen_count--;
            end
            REQ_APPEND:
            begin
                if (gen_count < CAPACITY)
                    gen_count++;
            end
            REQ_INSERT:
            begin
                if (r.loc <= gen_count && gen_count < CAPACITY)
                    gen_count++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_error(input string what, input rsp_t exp_r, input rsp_t got_r);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s exp st=%0d cnt=%0d cap=%0d val=%0d got st=%0d cnt=%0d cap=%0d val=%0d",
                     $realtime, what, exp_r.status, exp_r.count, exp_r.capacity,
                     exp_r.value_at_loc, got_r.status, got_r.count, got_r.capacity,
                     got_r.value_at_loc);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsps.push_back(apply_request(req));
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0 || pending_reqs.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    req_valid <= 1'b0;
                end
                else
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    gap_left = pick_gap(drv_calm);
                end
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                    report_error("unexpected transfer:", '0, rsp);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status || rsp.count !== want.count ||
                        rsp.capacity !== want.capacity ||
                        rsp.value_at_loc !== want.value_at_loc)
                        report_error("response mismatch:", want, rsp);
                end
                stall_left = pick_gap(mon_calm);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int seg;
        int mode;
        int r;
        int at;
        req_type_t op;

        // empty list: failing update, harmless delete, insert past the end
        add_item(REQ_UPDATE, 0, 32'h1111_1111);
        add_item(REQ_DELETE, 0, 32'h0);
        add_item(REQ_INSERT, 1, 32'h2222_2222);
        // insert at count behaves like append
        add_item(REQ_INSERT, 0, 32'h8000_0000);
        add_item(REQ_APPEND, 9, 32'h7FFF_FFFF);
        add_item(REQ_APPEND, 2, 32'hFFFF_FFFF);
        add_item(REQ_INSERT, 1, 32'h5555_5555);
        add_item(REQ_INSERT, 4, 32'h0000_0000);
        add_item(REQ_UPDATE, 2, 32'hAAAA_AAAA);
        add_item(REQ_UPDATE, 15, 32'h3333_3333);
        add_item(REQ_DELETE, 15, 32'h0);
        while (gen_count < CAPACITY)
            add_item(REQ_APPEND, $urandom_range(0, 15), rand_word());
        // store full
        add_item(REQ_APPEND, 15, 32'h4444_4444);
        add_item(REQ_INSERT, 0, 32'h6666_6666);
        add_item(REQ_UPDATE, 15, 32'h1234_5678);
        add_item(REQ_DELETE, 15, 32'h0);
        add_item(REQ_DELETE, 0, 32'h0);

        k = 0;
        while (k < RANDOM_ITEMS)
        begin
            seg = $urandom_range(10, 60);
            r = $urandom_range(0, 9);
            mode = (r < 3) ? 0 : (r < 6) ? 1 : (r < 9) ? 2 : 3;
            for (int j = 0; j < seg && k < RANDOM_ITEMS; j++)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: op = (r < 40) ? REQ_APPEND : (r < 75) ? REQ_INSERT :
                            (r < 88) ? REQ_UPDATE : REQ_DELETE;
                    1: op = (r < 70) ? REQ_DELETE : (r < 80) ? REQ_APPEND :
                            (r < 88) ? REQ_INSERT : REQ_UPDATE;
                    default: op = req_type_t'(r % 4);
                endcase
                if (mode == 3 || $urandom_range(0, 9) == 0 || op == REQ_APPEND)
                    at = $urandom_range(0, 15);
                else if (op == REQ_INSERT)
                    at = $urandom_range(0, (gen_count > 15) ? 15 : gen_count);
                else if (gen_count == 0)
                    at = $urandom_range(0, 15);
                else
                    at = $urandom_range(0, gen_count - 1);
                add_item(op, at, rand_word());
                k++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
